### hw/rtl/pht_pkg.sv
// Package for the pinned handle table: command and status codes, widths.
// No dependencies.
`default_nettype none
package pht_pkg;
  localparam int CMD_W = 2;
  localparam int HANDLE_W = 8;
  localparam int DATA_W = 64;
  localparam int STATUS_W = 2;
  localparam int THR_W = 9;
  localparam logic [THR_W-1:0] THR_RESET = 9'd32;

  localparam logic [CMD_W-1:0] CMD_PIN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNPIN = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_VALUE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;
endpackage
`default_nettype wire

### hw/rtl/pht_if.sv
// Valid/ready channel interfaces for the pinned handle table.
// Depends on pht_pkg.
`default_nettype none
interface pht_in_if;
  import pht_pkg::*;
  logic valid;
  logic ready;
  logic [CMD_W-1:0] command;
  logic value_present;
  logic [DATA_W-1:0] pin_value;
  logic [HANDLE_W-1:0] handle;
  modport source(output valid, command, value_present, pin_value, handle, input ready);
  modport sink(input valid, command, value_present, pin_value, handle, output ready);
endinterface

interface pht_out_if;
  import pht_pkg::*;
  logic valid;
  logic ready;
  logic [HANDLE_W-1:0] new_handle;
  logic [DATA_W-1:0] read_value;
  logic [STATUS_W-1:0] status;
  modport source(output valid, new_handle, read_value, status, input ready);
  modport sink(input valid, new_handle, read_value, status, output ready);
endinterface

interface pht_cfg_if;
  import pht_pkg::*;
  logic valid;
  logic ready;
  logic [THR_W-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/pinned_handle_table.sv
// Pinned handle table top level: slot memory, free-list memory, sequencer.
// Depends on pht_pkg and the channel interfaces in pht_if.sv.
`default_nettype none
// Pin reads the free-list top and then writes the slot; read reads the slot
// memory; unpin below the top slot clears it and pushes its handle on the free
// list. A pin passes through accept, free-list read, execute with slot write and
// result hand-off before the next acceptance; read and unpin skip the free-list
// read. The result word is valid the cycle after the hand-off and waits in its
// own output register, so a new item can be taken while it waits; the hand-off
// stage holds only while the previous word is still unclaimed. An unpin of the
// top slot that finds at least thr_r (and at least one) free entries sorts the
// free list in place with an insertion sort on the one-read one-write free-list
// memory and then trims trailing free slots; no input is taken meanwhile.
// Slot memory reads are only used below the used size, so no clearing pass.
module pinned_handle_table #(
  parameter int SLOTS = 256,
  parameter int VALUE_BITS = 64
) (
  input wire clk,
  input wire rst_n,
  pht_in_if.sink in_ch,
  pht_out_if.source out_ch,
  pht_cfg_if.sink cfg_ch
);
  import pht_pkg::*;
  localparam int IW = $clog2(SLOTS);
  localparam int CW = IW + 1;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_POP    = 10'b0000000010,
    S_EXEC   = 10'b0000000100,
    S_OUT    = 10'b0000001000,
    S_SRD_K  = 10'b0000010000,
    S_SRD_J  = 10'b0000100000,
    S_SCMP   = 10'b0001000000,
    S_SPUT   = 10'b0010000000,
    S_TRD    = 10'b0100000000,
    S_TCHK   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] used_r, used_nxt, free_r, free_nxt;
  logic [THR_W-1:0] thr_r;
  logic [CMD_W-1:0] cmd_r;
  logic pres_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [HANDLE_W-1:0] h_r;
  logic [CW-1:0] si_r, si_nxt, sj_r, sj_nxt;
  logic [IW-1:0] key_r, key_nxt;

  logic out_v_r;
  logic [HANDLE_W-1:0] nh_r, nh_nxt;
  logic [DATA_W-1:0] rv_r, rv_nxt;
  logic [STATUS_W-1:0] st_r, st_nxt;
  logic [HANDLE_W-1:0] out_nh_r;
  logic [DATA_W-1:0] out_rv_r;
  logic [STATUS_W-1:0] out_st_r;

  // memories
  logic [VALUE_BITS-1:0] slot_mem [SLOTS];
  logic [IW-1:0] free_mem [SLOTS];
  logic slot_we, free_we;
  logic [IW-1:0] slot_wa, slot_ra, free_wa, free_ra;
  logic [VALUE_BITS-1:0] slot_wd, slot_rd;
  logic [IW-1:0] free_wd, free_rd;

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd <= slot_mem[slot_ra];
  end
  always_ff @(posedge clk) begin
    if (free_we) free_mem[free_wa] <= free_wd;
    free_rd <= free_mem[free_ra];
  end

  wire in_fire = in_ch.valid && in_ch.ready;
  // hand the word over once the output register is free or being drained
  wire out_load = (state_r == S_OUT) && (!out_v_r || out_ch.ready);
  wire h_ok = ({{(32-HANDLE_W){1'b0}}, h_r} < 32'(used_r)) && (32'(h_r) < SLOTS);
  wire [CW-1:0] free_m1 = free_r - 1'b1;
  wire [CW-1:0] used_m1 = used_r - 1'b1;

  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_v_r;
  assign out_ch.new_handle = out_nh_r;
  assign out_ch.read_value = out_rv_r;
  assign out_ch.status = out_st_r;

  always_comb begin
    state_nxt = state_r;
    used_nxt = used_r;
    free_nxt = free_r;
    si_nxt = si_r;
    sj_nxt = sj_r;
    key_nxt = key_r;
    nh_nxt = nh_r;
    rv_nxt = rv_r;
    st_nxt = st_r;
    slot_we = 1'b0;
    slot_wa = IW'(h_r);
    slot_wd = val_r;
    slot_ra = IW'(in_ch.handle);
    free_we = 1'b0;
    free_wa = free_r[IW-1:0];
    free_wd = IW'(h_r);
    free_ra = free_m1[IW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          nh_nxt = '0;
          rv_nxt = '0;
          st_nxt = ST_OK;
          state_nxt = (in_ch.command == CMD_PIN) ? S_POP : S_EXEC;
        end
      end
      S_POP: state_nxt = S_EXEC; // free list top read in flight
      S_EXEC: begin
        state_nxt = S_OUT;
        case (cmd_r)
          CMD_PIN: begin
            if (!pres_r) begin
              st_nxt = ST_NO_VALUE;
            end else begin
              logic use_free;
              use_free = (free_r != '0) && (CW'(free_rd) < used_r);
              if (free_r != '0) free_nxt = free_m1;
              if (use_free) begin
                slot_we = 1'b1;
                slot_wa = free_rd;
                nh_nxt = HANDLE_W'(free_rd);
              end else if (32'(used_r) >= SLOTS) begin
                st_nxt = ST_FULL;
              end else begin
                slot_we = 1'b1;
                slot_wa = used_r[IW-1:0];
                nh_nxt = HANDLE_W'(used_r[IW-1:0]);
                used_nxt = used_r + 1'b1;
              end
            end
          end
          CMD_READ: begin
            if (h_ok) rv_nxt = DATA_W'(slot_rd);
            else st_nxt = ST_RANGE;
          end
          CMD_UNPIN: begin
            if (!h_ok) begin
              st_nxt = ST_RANGE;
            end else if (CW'(h_r) == used_m1) begin
              used_nxt = used_m1;
              if (32'(thr_r) <= 32'(free_r) && free_r != '0) begin
                si_nxt = CW'(1);
                state_nxt = S_SRD_K;
              end
            end else begin
              slot_we = 1'b1;
              slot_wd = '0;
              if (32'(free_r) < SLOTS) begin
                free_we = 1'b1;
                free_nxt = free_r + 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      // insertion sort: key = f[i], j = i; shift while f[j-1] > key
      S_SRD_K: begin
        if (si_r >= free_r) begin
          free_ra = free_m1[IW-1:0];
          state_nxt = S_TRD;
        end else begin
          free_ra = si_r[IW-1:0];
          sj_nxt = si_r;
          state_nxt = S_SRD_J;
        end
      end
      S_SRD_J: begin
        key_nxt = free_rd;
        free_ra = sj_r[IW-1:0] - 1'b1;
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (free_rd > key_r) begin
          free_we = 1'b1;
          free_wa = sj_r[IW-1:0];
          free_wd = free_rd;
          sj_nxt = sj_r - 1'b1;
          if (sj_r == CW'(1)) state_nxt = S_SPUT;
          else begin
            free_ra = sj_r[IW-1:0] - 2'd2;
            state_nxt = S_SCMP;
          end
        end else begin
          state_nxt = S_SPUT;
        end
      end
      S_SPUT: begin
        free_we = 1'b1;
        free_wa = sj_r[IW-1:0];
        free_wd = key_r;
        si_nxt = si_r + 1'b1;
        state_nxt = S_SRD_K;
      end
      S_TRD: state_nxt = S_TCHK;
      S_TCHK: begin
        if (free_r != '0 && used_r != '0 && CW'(free_rd) == used_m1) begin
          free_nxt = free_m1;
          used_nxt = used_m1;
          free_ra = free_r[IW-1:0] - 2'd2;
          state_nxt = S_TRD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: state_nxt = out_load ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
    // S_TRD issued read already in S_TCHK/S_SRD_K; keep address in S_TRD
    if (state_r == S_TRD) free_ra = free_m1[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r <= '0;
      free_r <= '0;
      thr_r <= THR_RESET;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r <= used_nxt;
      free_r <= free_nxt;
      if (cfg_ch.valid) thr_r <= cfg_ch.data;
      if (out_load) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    si_r <= si_nxt;
    sj_r <= sj_nxt;
    key_r <= key_nxt;
    nh_r <= nh_nxt;
    rv_r <= rv_nxt;
    st_r <= st_nxt;
    if (out_load) begin
      out_nh_r <= nh_r;
      out_rv_r <= rv_r;
      out_st_r <= st_r;
    end
    if (in_fire) begin
      cmd_r <= in_ch.command;
      pres_r <= in_ch.value_present;
      val_r <= in_ch.pin_value[VALUE_BITS-1:0];
      h_r <= in_ch.handle;
    end
  end

  property p_free_bound;
    @(posedge clk) disable iff (!rst_n) 32'(free_r) <= SLOTS;
  endproperty
  a_free_bound: assert property (p_free_bound) else $error("free count overflow");
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_r) <= SLOTS) else $error("used count overflow");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ch.ready) else $error("accept while busy");
  a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |=> out_v_r) else $error("result not presented");
endmodule
`default_nettype wire

### tb/sv/pinned_handle_table_tb.sv
// Testbench for pinned_handle_table: random and directed pin/read/unpin words
// are checked against a cycle-free predictor. Depends on pht_pkg and pht_if.sv.
`default_nettype none
module pinned_handle_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pht_pkg::*;

  localparam int NSLOT = 256;
  localparam int IDLE_LIMIT = 600000;
  localparam int CFG_IDX = 0;

  typedef struct packed {
    logic [HANDLE_W-1:0] new_handle;
    logic [DATA_W-1:0] read_value;
    logic [STATUS_W-1:0] status;
  } answer_t;

  class handle_table_sb;
    logic [DATA_W-1:0] slots[NSLOT];
    int free_stack[NSLOT];
    int used;
    int nfree;
    int thresh;
    answer_t answers_due[$];
    int errors;

    function new();
      used = 0;
      nfree = 0;
      thresh = THR_RESET;
      errors = 0;
    endfunction

    function void sort_free_stack();
      int key;
      int j;
      for (int i = 1; i < nfree; i++) begin
        key = free_stack[i];
        j = i;
        while (j > 0 && free_stack[j-1] > key) begin
          free_stack[j] = free_stack[j-1];
          j--;
        end
        free_stack[j] = key;
      end
    endfunction

    // Apply one accepted word to the table copy and queue its answer.
    function void note_input(logic [CMD_W-1:0] cmd, logic present,
                             logic [DATA_W-1:0] val, logic [HANDLE_W-1:0] h);
      answer_t a;
      int slot;
      int cand;
      a = '0;
      a.status = ST_OK;
      if (cmd == CMD_PIN) begin
        if (!present) begin
          a.status = ST_NO_VALUE;
        end else begin
          slot = NSLOT;
          if (nfree > 0) begin
            cand = free_stack[nfree-1];
            nfree--;
            if (cand < used) slot = cand;
          end
          if (slot == NSLOT) begin
            if (used >= NSLOT) a.status = ST_FULL;
            else begin
              slot = used;
              used++;
            end
          end
          if (a.status == ST_OK) begin
            slots[slot] = val;
            a.new_handle = slot[HANDLE_W-1:0];
          end
        end
      end else if (cmd == CMD_READ) begin
        if (h < used) a.read_value = slots[h];
        else a.status = ST_RANGE;
      end else if (cmd == CMD_UNPIN) begin
        if (h >= used) begin
          a.status = ST_RANGE;
        end else if (h == used - 1) begin
          used--;
          if (nfree >= thresh) begin
            sort_free_stack();
            while (nfree > 0 && used > 0 && free_stack[nfree-1] == used - 1) begin
              nfree--;
              used--;
            end
          end
        end else begin
          slots[h] = '0;
          if (nfree < NSLOT) begin
            free_stack[nfree] = h;
            nfree++;
          end
        end
      end
      answers_due = {answers_due, a};
    endfunction

    function void check_result(answer_t got);
      answer_t exp_a;
      if (answers_due.size() == 0) begin
        $error("result word with nothing outstanding");
        errors++;
        return;
      end
      exp_a = answers_due.pop_front();
      if (got.new_handle !== exp_a.new_handle) begin
        $error("new_handle exp %0d got %0d", exp_a.new_handle, got.new_handle);
        errors++;
      end
      if (got.read_value !== exp_a.read_value) begin
        $error("read_value exp %h got %h", exp_a.read_value, got.read_value);
        errors++;
      end
      if (got.status !== exp_a.status) begin
        $error("status exp %0d got %0d", exp_a.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  pht_in_if in_ch();
  pht_out_if out_ch();
  pht_cfg_if cfg_ch();
  handle_table_sb sb;
  int idle_cycles;
  bit gaps_on;

  pinned_handle_table u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial sb = new();

  // Observe handshakes and run the idle watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_input(in_ch.command, in_ch.value_present, in_ch.pin_value, in_ch.handle);
      if (out_ch.valid && out_ch.ready)
        sb.check_result({out_ch.new_handle, out_ch.read_value, out_ch.status});
      if (cfg_ch.valid && cfg_ch.ready) sb.thresh = cfg_ch.data;
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side: random back-pressure per word.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = gaps_on ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_word(logic [CMD_W-1:0] cmd, logic present,
                           logic [DATA_W-1:0] val, logic [HANDLE_W-1:0] h);
    int gap;
    gap = gaps_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.value_present <= present;
    in_ch.pin_value <= val;
    in_ch.handle <= h;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.answers_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_threshold(int thr);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= thr[THR_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [HANDLE_W-1:0] pick_handle();
    int r;
    r = $urandom_range(0, 99);
    if (sb.used > 0 && r < 55) return HANDLE_W'($urandom_range(0, sb.used - 1));
    if (sb.used > 0 && r < 85) return HANDLE_W'(sb.used - 1);
    return HANDLE_W'($urandom_range(0, NSLOT - 1));
  endfunction

  // pin_pct / read_pct weight the command mix; the remainder is mostly unpin.
  task automatic random_words(int count, int pin_pct, int read_pct);
    int r;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      if (i == count / 2) drain_results();
      r = $urandom_range(0, 99);
      if (r < pin_pct)
        send_word(CMD_PIN, $urandom_range(0, 19) != 0, pick_value(), pick_handle());
      else if (r < pin_pct + read_pct)
        send_word(CMD_READ, 1'($urandom_range(0, 1)), pick_value(), pick_handle());
      else if (r < 97)
        send_word(CMD_UNPIN, 1'($urandom_range(0, 1)), pick_value(), pick_handle());
      else
        send_word(CMD_NOP, 1'($urandom_range(0, 1)), pick_value(), pick_handle());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    idle_cycles = 0;
    gaps_on = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_PIN;
    in_ch.value_present = 1'b0;
    in_ch.pin_value = '0;
    in_ch.handle = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty table, extremes, double unpin, stale free entries.
    send_word(CMD_PIN, 1'b0, '1, 8'd0);
    send_word(CMD_READ, 1'b1, '0, 8'd0);
    send_word(CMD_UNPIN, 1'b1, '0, 8'd0);
    send_word(CMD_NOP, 1'b1, '1, 8'hff);
    send_word(CMD_PIN, 1'b1, '0, 8'd0);
    send_word(CMD_PIN, 1'b1, '1, 8'hff);
    send_word(CMD_PIN, 1'b1, 64'h8000_0000_0000_0001, 8'd0);
    send_word(CMD_PIN, 1'b1, 64'h5555_aaaa_5555_aaaa, 8'd0);
    send_word(CMD_READ, 1'b0, '0, 8'd1);
    send_word(CMD_READ, 1'b0, '0, 8'd3);
    send_word(CMD_READ, 1'b0, '0, 8'd4);
    send_word(CMD_READ, 1'b0, '0, 8'hff);
    send_word(CMD_UNPIN, 1'b0, '0, 8'd1);
    send_word(CMD_UNPIN, 1'b0, '0, 8'd1);
    send_word(CMD_READ, 1'b0, '0, 8'd1);
    send_word(CMD_PIN, 1'b1, 64'h1234, 8'd0);
    send_word(CMD_PIN, 1'b1, 64'h5678, 8'd0);
    send_word(CMD_UNPIN, 1'b0, '0, 8'd2);
    send_word(CMD_UNPIN, 1'b0, '0, 8'd3);
    send_word(CMD_UNPIN, 1'b0, '0, 8'd2);
    send_word(CMD_PIN, 1'b1, 64'h9abc, 8'd0);
    send_word(CMD_UNPIN, 1'b0, '0, 8'hff);
    send_word(CMD_READ, 1'b0, '0, 8'd0);

    write_threshold(1);
    random_words(200, 35, 20);
    write_threshold(2);
    random_words(200, 38, 20);
    write_threshold(17);
    random_words(200, 40, 20);
    // Fill to the top and past it, then free heavily to overflow the list.
    write_threshold(256);
    random_words(320, 90, 5);
    random_words(200, 5, 10);
    write_threshold(32);
    random_words(250, 40, 20);

    drain_results();
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire

### files.f
hw/rtl/pht_pkg.sv
hw/rtl/pht_if.sv
hw/rtl/pinned_handle_table.sv
tb/sv/pinned_handle_table_tb.sv
